/* hw/rtl/dual_queue_shortest_join_dispatch_top_assert.svh */
// Assertion macros for the checker file of the dispatcher.
// Each macro is evaluated on the rising clock edge and is switched off
// while reset is high.
`ifndef DUAL_QUEUE_SHORTEST_JOIN_DISPATCH_TOP_ASSERT_SVH
`define DUAL_QUEUE_SHORTEST_JOIN_DISPATCH_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DQSJ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQSJ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dqsj_pkg.sv */
`default_nettype none
package dqsj_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int TICK_W  = 32;
   localparam int SVC_W   = 4;
   localparam int TOTAL_W = 32;
   localparam int SUM_W   = 40;

   typedef struct packed {
      logic [TICK_W-1:0] arrive;
      logic [SVC_W-1:0]  service;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Events of one finished tick, handed to the statistics unit.
   typedef struct packed {
      logic              fire;
      logic              joined;
      logic              turned;
      logic [1:0]        started;
      logic [TICK_W-1:0] wait_one;
      logic [TICK_W-1:0] wait_two;
      logic [CNT_W-1:0]  length_one;
      logic [CNT_W-1:0]  length_two;
   } stats_event_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/dual_queue_shortest_join_dispatch_top.sv */
// Two-server join-shortest-queue dispatcher. Each item on the req_ channel
// is one simulated tick: req_arrival says whether a job arrives and
// req_service_time gives the ticks it will occupy its server. For every
// item exactly one result leaves on the rsp_ channel: whether the job
// joined a queue or was turned away, which queue it joined, how many jobs
// started service, both queue lengths after the tick and the saturating
// totals and sums. Both channels use valid and stall.
// An accepted item takes the block to ST_EXEC, and the queue heads are
// read from synchronous RAMs at the accepting edge; the result register
// is loaded as ST_EXEC is left. No new item is taken while in ST_EXEC.
// While a result waits under rsp_stall the next item is still accepted and
// its queue heads read, but it is not finished until the waiting result
// has been taken; req_stall stays high meanwhile.
// Reset is synchronous: queues empty, servers idle, tick counter and all
// totals zero, no result pending. No clearing pass is needed, as queue
// entries are only ever used after they have been written.
`default_nettype none
module dual_queue_shortest_join_dispatch_top import dqsj_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_arrival,
   input  wire logic [SVC_W-1:0]   req_service_time,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_joined,
   output      logic               rsp_turned_away,
   output      logic               rsp_queue_chosen,
   output      logic [1:0]         rsp_started_service,
   output      logic [CNT_W-1:0]   rsp_length_one,
   output      logic [CNT_W-1:0]   rsp_length_two,
   output      logic [TOTAL_W-1:0] rsp_customers_total,
   output      logic [TOTAL_W-1:0] rsp_served_total,
   output      logic [TOTAL_W-1:0] rsp_rejected_total,
   output      logic [SUM_W-1:0]   rsp_length_sum,
   output      logic [SUM_W-1:0]   rsp_wait_sum
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              joined_ff, joined_in;
   logic              turned_ff, turned_in;
   logic              chosen_ff, chosen_in;
   logic [1:0]        started_ff, started_in;

   logic              arrival_ff;
   logic [SVC_W-1:0]  service_ff;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [PTR_W-1:0]  head1_ff, head1_in, tail1_ff, tail1_in;
   logic [PTR_W-1:0]  head2_ff, head2_in, tail2_ff, tail2_in;
   logic [CNT_W-1:0]  cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [SVC_W-1:0]  rem1_ff, rem1_in, rem2_ff, rem2_in;

   logic              accept, exec_go;
   logic              full1, full2, take, pick_two, push1, push2;
   logic [CNT_W-1:0]  cnt1_mid, cnt2_mid;
   logic              serve1, serve2;
   logic [SVC_W-1:0]  load1, load2;
   entry_type         new_entry, rd1_entry, rd2_entry, pop1_entry, pop2_entry;
   logic [ENTRY_W-1:0] rd1_bits, rd2_bits;
   stats_event_type   stats_event;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign new_entry.arrive  = tick_ff;
   assign new_entry.service = service_ff;
   assign rd1_entry = entry_type'(rd1_bits);
   assign rd2_entry = entry_type'(rd2_bits);

   dqsj_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W),
      .DATA_W (ENTRY_W)
   ) u_ram_one (
      .clock   (clock),
      .wr_en   (exec_go && push1),
      .wr_addr (tail1_ff),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (head1_ff),
      .rd_data (rd1_bits)
   );

   dqsj_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W),
      .DATA_W (ENTRY_W)
   ) u_ram_two (
      .clock   (clock),
      .wr_en   (exec_go && push2),
      .wr_addr (tail2_ff),
      .wr_data (new_entry),
      .rd_en   (accept),
      .rd_addr (head2_ff),
      .rd_data (rd2_bits)
   );

   always_comb begin
      full1    = (cnt1_ff == FULL_COUNT);
      full2    = (cnt2_ff == FULL_COUNT);
      take     = arrival_ff && !(full1 && full2);
      if (full1) begin
         pick_two = 1'b1;
      end else if (full2) begin
         pick_two = 1'b0;
      end else begin
         pick_two = (cnt1_ff > cnt2_ff);
      end
      push1    = take && !pick_two;
      push2    = take && pick_two;
      cnt1_mid = cnt1_ff + CNT_W'(push1);
      cnt2_mid = cnt2_ff + CNT_W'(push2);
      serve1   = (rem1_ff == '0) && (cnt1_mid != '0);
      serve2   = (rem2_ff == '0) && (cnt2_mid != '0);
      // A queue that was empty can only pop the job pushed in this very
      // tick, which is not yet in the RAM, so it is forwarded.
      pop1_entry = (cnt1_ff == '0) ? new_entry : rd1_entry;
      pop2_entry = (cnt2_ff == '0) ? new_entry : rd2_entry;
      load1    = serve1 ? pop1_entry.service : rem1_ff;
      load2    = serve2 ? pop2_entry.service : rem2_ff;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      joined_in    = joined_ff;
      turned_in    = turned_ff;
      chosen_in    = chosen_ff;
      started_in   = started_ff;
      tick_in      = tick_ff;
      head1_in     = head1_ff;
      tail1_in     = tail1_ff;
      head2_in     = head2_ff;
      tail2_in     = tail2_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      rem1_in      = rem1_ff;
      rem2_in      = rem2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               joined_in    = take;
               turned_in    = arrival_ff && full1 && full2;
               chosen_in    = push2;
               started_in   = 2'(serve1) + 2'(serve2);
               tick_in      = tick_ff + TICK_W'(1);
               if (push1) begin
                  tail1_in = ptr_next(tail1_ff);
               end
               if (push2) begin
                  tail2_in = ptr_next(tail2_ff);
               end
               if (serve1) begin
                  head1_in = ptr_next(head1_ff);
               end
               if (serve2) begin
                  head2_in = ptr_next(head2_ff);
               end
               cnt1_in = cnt1_mid - CNT_W'(serve1);
               cnt2_in = cnt2_mid - CNT_W'(serve2);
               rem1_in = (load1 != '0) ? load1 - SVC_W'(1) : load1;
               rem2_in = (load2 != '0) ? load2 - SVC_W'(1) : load2;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      stats_event.fire       = exec_go;
      stats_event.joined     = take;
      stats_event.turned     = arrival_ff && full1 && full2;
      stats_event.started    = 2'(serve1) + 2'(serve2);
      stats_event.wait_one   = serve1 ? tick_ff - pop1_entry.arrive : '0;
      stats_event.wait_two   = serve2 ? tick_ff - pop2_entry.arrive : '0;
      stats_event.length_one = cnt1_in;
      stats_event.length_two = cnt2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         head1_ff     <= '0;
         tail1_ff     <= '0;
         head2_ff     <= '0;
         tail2_ff     <= '0;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         rem1_ff      <= '0;
         rem2_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         head1_ff     <= head1_in;
         tail1_ff     <= tail1_in;
         head2_ff     <= head2_in;
         tail2_ff     <= tail2_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         rem1_ff      <= rem1_in;
         rem2_ff      <= rem2_in;
      end
      joined_ff  <= joined_in;
      turned_ff  <= turned_in;
      chosen_ff  <= chosen_in;
      started_ff <= started_in;
      if (accept) begin
         arrival_ff <= req_arrival;
         service_ff <= req_service_time;
      end
   end

   dqsj_stats u_stats (
      .clock           (clock),
      .reset           (reset),
      .event_in        (stats_event),
      .customers_total (rsp_customers_total),
      .served_total    (rsp_served_total),
      .rejected_total  (rsp_rejected_total),
      .length_sum      (rsp_length_sum),
      .wait_sum        (rsp_wait_sum)
   );

   // Lengths and totals only change when a tick finishes, which is also
   // when the result register is loaded, so they serve as result fields.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_joined          = joined_ff;
   assign rsp_turned_away     = turned_ff;
   assign rsp_queue_chosen    = chosen_ff;
   assign rsp_started_service = started_ff;
   assign rsp_length_one      = cnt1_ff;
   assign rsp_length_two      = cnt2_ff;

endmodule
`default_nettype wire

/* hw/rtl/dqsj_ram.sv */
`default_nettype none
module dqsj_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 36
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/dqsj_stats.sv */
`default_nettype none
module dqsj_stats import dqsj_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stats_event_type  event_in,
   output      logic [TOTAL_W-1:0] customers_total,
   output      logic [TOTAL_W-1:0] served_total,
   output      logic [TOTAL_W-1:0] rejected_total,
   output      logic [SUM_W-1:0]   length_sum,
   output      logic [SUM_W-1:0]   wait_sum
);

   localparam logic [TOTAL_W-1:0] MAX_TOTAL = '1;
   localparam logic [SUM_W-1:0]   MAX_SUM   = '1;

   logic [TOTAL_W-1:0] accepted_ff, accepted_in;
   logic [TOTAL_W-1:0] served_ff, served_in;
   logic [TOTAL_W-1:0] rejected_ff, rejected_in;
   logic [SUM_W-1:0]   length_ff, length_in;
   logic [SUM_W-1:0]   wait_ff, wait_in;

   logic [TOTAL_W:0]   served_wide;
   logic [SUM_W:0]     length_wide;
   logic [SUM_W+1:0]   wait_wide;

   always_comb begin
      accepted_in = accepted_ff;
      rejected_in = rejected_ff;
      served_wide = {1'b0, served_ff} + (TOTAL_W + 1)'(event_in.started);
      length_wide = {1'b0, length_ff} + (SUM_W + 1)'(event_in.length_one)
                    + (SUM_W + 1)'(event_in.length_two);
      // Both delays go in together; saturating once at the end gives the
      // same answer as saturating after each addition.
      wait_wide   = {2'b00, wait_ff} + (SUM_W + 2)'(event_in.wait_one)
                    + (SUM_W + 2)'(event_in.wait_two);
      served_in   = served_ff;
      length_in   = length_ff;
      wait_in     = wait_ff;
      if (event_in.fire) begin
         if (event_in.joined && accepted_ff != MAX_TOTAL) begin
            accepted_in = accepted_ff + TOTAL_W'(1);
         end
         if (event_in.turned && rejected_ff != MAX_TOTAL) begin
            rejected_in = rejected_ff + TOTAL_W'(1);
         end
         served_in = served_wide[TOTAL_W] ? MAX_TOTAL : served_wide[TOTAL_W-1:0];
         length_in = length_wide[SUM_W] ? MAX_SUM : length_wide[SUM_W-1:0];
         wait_in   = (wait_wide[SUM_W+1:SUM_W] != 2'b00) ? MAX_SUM
                                                         : wait_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= '0;
         served_ff   <= '0;
         rejected_ff <= '0;
         length_ff   <= '0;
         wait_ff     <= '0;
      end else begin
         accepted_ff <= accepted_in;
         served_ff   <= served_in;
         rejected_ff <= rejected_in;
         length_ff   <= length_in;
         wait_ff     <= wait_in;
      end
   end

   assign customers_total = accepted_ff;
   assign served_total    = served_ff;
   assign rejected_total  = rejected_ff;
   assign length_sum      = length_ff;
   assign wait_sum        = wait_ff;

endmodule
`default_nettype wire

/* hw/rtl/dqsj_checker.sv */
`default_nettype none
`include "dual_queue_shortest_join_dispatch_top_assert.svh"
module dqsj_checker import dqsj_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_joined,
   input wire logic               rsp_turned_away,
   input wire logic               rsp_queue_chosen,
   input wire logic [CNT_W-1:0]   rsp_length_one,
   input wire logic [CNT_W-1:0]   rsp_length_two,
   input wire logic [TOTAL_W-1:0] rsp_customers_total
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   `DQSJ_ASSERT_NOW(a_join_or_reject, rsp_valid, !(rsp_joined && rsp_turned_away), "job both joined and turned away")
   `DQSJ_ASSERT_NOW(a_choice_needs_join, rsp_valid && rsp_queue_chosen, rsp_joined, "second queue chosen without a join")
   `DQSJ_ASSERT_NOW(a_length_bound, rsp_valid, (rsp_length_one <= FULL_COUNT) && (rsp_length_two <= FULL_COUNT), "queue length beyond depth")
   `DQSJ_ASSERT_NEXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_customers_total), "stalled result changed")

endmodule

bind dual_queue_shortest_join_dispatch_top dqsj_checker u_dqsj_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_joined          (rsp_joined),
   .rsp_turned_away     (rsp_turned_away),
   .rsp_queue_chosen    (rsp_queue_chosen),
   .rsp_length_one      (rsp_length_one),
   .rsp_length_two      (rsp_length_two),
   .rsp_customers_total (rsp_customers_total)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import dqsj_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic               joined;
      logic               turned_away;
      logic               queue_chosen;
      logic [1:0]         started;
      logic [CNT_W-1:0]   len_one;
      logic [CNT_W-1:0]   len_two;
      logic [TOTAL_W-1:0] customers;
      logic [TOTAL_W-1:0] served;
      logic [TOTAL_W-1:0] rejected;
      logic [SUM_W-1:0]   len_sum;
      logic [SUM_W-1:0]   wait_sum;
   } tick_outcome_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_arrival;
   logic [SVC_W-1:0]   req_service_time;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_joined;
   logic               rsp_turned_away;
   logic               rsp_queue_chosen;
   logic [1:0]         rsp_started_service;
   logic [CNT_W-1:0]   rsp_length_one;
   logic [CNT_W-1:0]   rsp_length_two;
   logic [TOTAL_W-1:0] rsp_customers_total;
   logic [TOTAL_W-1:0] rsp_served_total;
   logic [TOTAL_W-1:0] rsp_rejected_total;
   logic [SUM_W-1:0]   rsp_length_sum;
   logic [SUM_W-1:0]   rsp_wait_sum;

   // Shadow state of the dispatcher.
   entry_type          waiting_one[$];
   entry_type          waiting_two[$];
   logic [TICK_W-1:0]  tick_now;
   logic [SVC_W-1:0]   countdown_one;
   logic [SVC_W-1:0]   countdown_two;
   logic [TOTAL_W-1:0] accepted_jobs;
   logic [TOTAL_W-1:0] served_jobs;
   logic [TOTAL_W-1:0] rejected_jobs;
   logic [SUM_W-1:0]   length_total;
   logic [SUM_W-1:0]   delay_total;

   tick_outcome_type   pending_outcomes[$];

   int  mismatch_count;
   int  results_seen;
   int  ticks_sent;
   int  turned_away_seen;
   int  peak_one;
   int  peak_two;
   int  cycle_count;
   bit  steady_flow;

   dual_queue_shortest_join_dispatch_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival         (req_arrival),
      .req_service_time    (req_service_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_joined          (rsp_joined),
      .rsp_turned_away     (rsp_turned_away),
      .rsp_queue_chosen    (rsp_queue_chosen),
      .rsp_started_service (rsp_started_service),
      .rsp_length_one      (rsp_length_one),
      .rsp_length_two      (rsp_length_two),
      .rsp_customers_total (rsp_customers_total),
      .rsp_served_total    (rsp_served_total),
      .rsp_rejected_total  (rsp_rejected_total),
      .rsp_length_sum      (rsp_length_sum),
      .rsp_wait_sum        (rsp_wait_sum)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [TICK_W:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + b;
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   // An idle server takes the head of its queue and books the time it waited.
   function automatic logic take_head(ref logic [SVC_W-1:0] countdown,
                                      ref entry_type line[$]);
      entry_type         job;
      logic [TICK_W-1:0] delay;
      if (countdown != '0 || line.size() == 0) begin
         return 1'b0;
      end
      job = line.pop_front();
      countdown = job.service;
      delay = tick_now - job.arrive;
      delay_total = sat_add(delay_total, {1'b0, delay});
      served_jobs = sat_inc(served_jobs);
      return 1'b1;
   endfunction

   function automatic void predict_tick(input logic arr, input logic [SVC_W-1:0] svc);
      tick_outcome_type o;
      logic          full_one;
      logic          full_two;
      entry_type     job;
      o = '{default: '0};
      full_one = waiting_one.size() >= QUEUE_DEPTH;
      full_two = waiting_two.size() >= QUEUE_DEPTH;
      if (arr) begin
         if (full_one && full_two) begin
            o.turned_away = 1'b1;
            rejected_jobs = sat_inc(rejected_jobs);
         end else begin
            o.joined = 1'b1;
            accepted_jobs = sat_inc(accepted_jobs);
            if (full_one) begin
               o.queue_chosen = 1'b1;
            end else if (full_two) begin
               o.queue_chosen = 1'b0;
            end else begin
               o.queue_chosen = waiting_one.size() > waiting_two.size();
            end
            job.arrive = tick_now;
            job.service = svc;
            if (o.queue_chosen) begin
               waiting_two.push_back(job);
            end else begin
               waiting_one.push_back(job);
            end
         end
      end
      o.started = 2'(take_head(countdown_one, waiting_one));
      o.started = o.started + 2'(take_head(countdown_two, waiting_two));
      if (countdown_one != '0) begin
         countdown_one = countdown_one - 1'b1;
      end
      if (countdown_two != '0) begin
         countdown_two = countdown_two - 1'b1;
      end
      length_total = sat_add(length_total, (TICK_W+1)'(waiting_one.size() + waiting_two.size()));
      tick_now = tick_now + 1'b1;

      o.len_one   = CNT_W'(waiting_one.size());
      o.len_two   = CNT_W'(waiting_two.size());
      o.customers = accepted_jobs;
      o.served    = served_jobs;
      o.rejected  = rejected_jobs;
      o.len_sum   = length_total;
      o.wait_sum  = delay_total;
      pending_outcomes.push_back(o);

      if (o.turned_away) begin
         turned_away_seen++;
      end
      if (waiting_one.size() > peak_one) begin
         peak_one = waiting_one.size();
      end
      if (waiting_two.size() > peak_two) begin
         peak_two = waiting_two.size();
      end
   endfunction

   // Offers one tick and returns once the block has taken it.
   task automatic send_tick(input logic arr, input logic [SVC_W-1:0] svc);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_arrival      <= arr;
      req_service_time <= svc;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_tick(arr, svc);
      ticks_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic compare_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d, %s: expected %0h, got %0h",
                     results_seen, label, want, got);
         end
      end
   endtask

   task automatic check_result();
      tick_outcome_type o;
      if (pending_outcomes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d arrived with no tick outstanding", results_seen);
         end
      end else begin
         o = pending_outcomes.pop_front();
         compare_field("joined", 64'(o.joined), 64'(rsp_joined));
         compare_field("turned_away", 64'(o.turned_away), 64'(rsp_turned_away));
         compare_field("queue_chosen", 64'(o.queue_chosen), 64'(rsp_queue_chosen));
         compare_field("started_service", 64'(o.started), 64'(rsp_started_service));
         compare_field("length_one", 64'(o.len_one), 64'(rsp_length_one));
         compare_field("length_two", 64'(o.len_two), 64'(rsp_length_two));
         compare_field("customers_total", 64'(o.customers), 64'(rsp_customers_total));
         compare_field("served_total", 64'(o.served), 64'(rsp_served_total));
         compare_field("rejected_total", 64'(o.rejected), 64'(rsp_rejected_total));
         compare_field("length_sum", 64'(o.len_sum), 64'(rsp_length_sum));
         compare_field("wait_sum", 64'(o.wait_sum), 64'(rsp_wait_sum));
      end
      results_seen++;
   endtask

   // Result side: a random hold-off before each item outside steady flow, then take it.
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 3);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (!rsp_valid);
         check_result();
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

   // Idle ticks, a lone job, zero and maximum service times and the tie rule.
   task automatic test_directed_edges();
      send_tick(1'b0, 4'd0);
      send_tick(1'b0, 4'd15);
      send_tick(1'b1, 4'd1);
      send_tick(1'b1, 4'd0);
      send_tick(1'b1, 4'd0);
      send_tick(1'b0, 4'd0);
      send_tick(1'b1, 4'd15);
      send_tick(1'b1, 4'd15);
      send_tick(1'b1, 4'd15);
      send_tick(1'b1, 4'd10);
      send_tick(1'b1, 4'd5);
      send_tick(1'b1, 4'd3);
      send_tick(1'b0, 4'd7);
      send_tick(1'b1, 4'd2);
      send_tick(1'b1, 4'd0);
      send_tick(1'b0, 4'd8);
      send_tick(1'b1, 4'd4);
      send_tick(1'b0, 4'd0);
      send_tick(1'b1, 4'd9);
      send_tick(1'b0, 4'd0);
   endtask

   // Long jobs arriving every tick fill both queues until jobs are turned away.
   task automatic test_queue_overflow();
      repeat (48) begin
         send_tick(1'b1, 4'd15);
      end
      repeat (6) begin
         send_tick(1'b1, 4'($urandom_range(0, 15)));
      end
      hold_until_drained();
   endtask

   // Segments of heavy, light and mixed load, some with no idling on either side.
   task automatic test_random_traffic(input int items);
      int               left;
      int               seg;
      int               mode;
      int               load_pct;
      int               svc_lo;
      int               svc_hi;
      logic             arr;
      logic [SVC_W-1:0] svc;
      bit               paused;
      left = items;
      paused = 1'b0;
      while (left > 0) begin
         seg = $urandom_range(20, 80);
         if (seg > left) begin
            seg = left;
         end
         mode = $urandom_range(0, 3);
         steady_flow = (mode == 3);
         case (mode)
            0: begin
               load_pct = 90;
               svc_lo = 8;
               svc_hi = 15;
            end
            1: begin
               load_pct = 15;
               svc_lo = 0;
               svc_hi = 3;
            end
            default: begin
               load_pct = 50;
               svc_lo = 0;
               svc_hi = 15;
            end
         endcase
         repeat (seg) begin
            arr = $urandom_range(0, 99) < load_pct;
            svc = arr ? SVC_W'($urandom_range(svc_lo, svc_hi))
                      : SVC_W'($urandom_range(0, 15));
            send_tick(arr, svc);
         end
         left -= seg;
         if (!paused && left < items / 2) begin
            steady_flow = 1'b0;
            hold_until_drained();
            paused = 1'b1;
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_arrival      = 1'b0;
      req_service_time = '0;
      rsp_stall        = 1'b0;
      steady_flow      = 1'b0;
      tick_now         = '0;
      countdown_one    = '0;
      countdown_two    = '0;
      accepted_jobs    = '0;
      served_jobs      = '0;
      rejected_jobs    = '0;
      length_total     = '0;
      delay_total      = '0;
      mismatch_count   = 0;
      results_seen     = 0;
      ticks_sent       = 0;
      turned_away_seen = 0;
      peak_one         = 0;
      peak_two         = 0;
      cycle_count      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_queue_overflow();
      test_random_traffic(1430);

      hold_until_drained();
      repeat (10) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         mismatch_count++;
         $display("%0d ticks never produced a result", pending_outcomes.size());
      end

      $display("Sent %0d ticks, checked %0d results, %0d jobs turned away.",
               ticks_sent, results_seen, turned_away_seen);
      $display("Peak queue lengths %0d and %0d, %0d mismatches.",
               peak_one, peak_two, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
